@@ sv/ip5t_pkg.sv @@
// ip5t_pkg: shared constants and types for the ipv4 five-tuple extractor
// no dependencies; imported by the channel interfaces and the top level

package ip5t_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned LEN_W    = 16;
    localparam int unsigned ADDR_W   = 32;
    localparam int unsigned PORT_W   = 16;
    localparam int unsigned PROTO_W  = 8;
    localparam int unsigned OFFSET_W = 7;

    typedef logic [OFFSET_W-1:0] t_offset;

    localparam t_offset OFFSET_MAX     = 7'd127;
    localparam t_offset ETYPE_HI_OFF   = 7'd12;
    localparam t_offset ETYPE_LO_OFF   = 7'd13;
    localparam t_offset IP_START       = 7'd14;
    localparam t_offset PROTO_OFF      = 7'd23;
    localparam t_offset SRC_ADDR_OFF   = 7'd26;
    localparam t_offset DST_ADDR_OFF   = 7'd30;

    localparam logic [15:0]        ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [PROTO_W-1:0] PROTO_ICMP     = 8'd1;
    localparam logic [PROTO_W-1:0] PROTO_TCP      = 8'd6;
    localparam logic [PROTO_W-1:0] PROTO_UDP      = 8'd17;

    typedef struct packed {
        logic [LEN_W-1:0]   frame_length;
        logic               is_ipv4;
        logic [ADDR_W-1:0]  src_addr;
        logic [ADDR_W-1:0]  dst_addr;
        logic [PORT_W-1:0]  sport;
        logic [PORT_W-1:0]  dport;
        logic [PROTO_W-1:0] proto_num;
    } t_summary;

endpackage

@@ sv/ip5t_if.sv @@
// ip5t_if: valid/ready channel interfaces for frame bytes and frame summaries
// depends on ip5t_pkg for field widths

interface ip5t_in_if
    import ip5t_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              last_byte;
    logic [LEN_W-1:0]  wire_length;

    modport source (output valid, output data_byte, output last_byte,
                    output wire_length, input ready);
    modport sink   (input valid, input data_byte, input last_byte,
                    input wire_length, output ready);
endinterface

interface ip5t_out_if
    import ip5t_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [LEN_W-1:0]   frame_length;
    logic               is_ipv4;
    logic [ADDR_W-1:0]  src_addr;
    logic [ADDR_W-1:0]  dst_addr;
    logic [PORT_W-1:0]  sport;
    logic [PORT_W-1:0]  dport;
    logic [PROTO_W-1:0] proto_num;

    modport source (output valid, output frame_length, output is_ipv4,
                    output src_addr, output dst_addr, output sport,
                    output dport, output proto_num, input ready);
    modport sink   (input valid, input frame_length, input is_ipv4,
                    input src_addr, input dst_addr, input sport,
                    input dport, input proto_num, output ready);
endinterface

@@ sv/ipv4_five_tuple_extractor_top.sv @@
// Takes an Ethernet frame one byte per transaction on i_in and gives at most one summary
// per frame on o_out. Each byte passes an input register and one level of offset compare
// and capture logic; the last byte of a frame also loads the summary register. A byte is
// accepted every cycle while o_out keeps up, so throughput is one byte per cycle, and
// o_out.valid rises when the last byte leaves the input register and loads the summary
// register. A held summary stalls input only when the next frame's last byte needs it.
// Non-IPv4 frames report only their length, ICMP gives zero ports, and IPv4 frames with
// any other protocol give no summary. Header fields past the end of a frame read as zero.

module ipv4_five_tuple_extractor_top
    import ip5t_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    ip5t_in_if.sink    i_in,
    ip5t_out_if.source o_out
);

    // input register
    logic              r_s1_valid;
    logic [BYTE_W-1:0] r_s1_byte;
    logic              r_s1_last;
    logic [LEN_W-1:0]  r_s1_wlen;

    // per-frame parse state
    t_offset            r_offset,   n_offset;
    logic [15:0]        r_ether,    n_ether;
    logic [3:0]         r_hwords,   n_hwords;
    logic [PROTO_W-1:0] r_proto,    n_proto;
    logic [ADDR_W-1:0]  r_src_addr, n_src_addr;
    logic [ADDR_W-1:0]  r_dst_addr, n_dst_addr;
    logic [PORT_W-1:0]  r_sport,    n_sport;
    logic [PORT_W-1:0]  r_dport,    n_dport;

    // result register
    logic     r_out_valid;
    t_summary r_out;
    t_summary n_summary;

    logic       out_free;
    logic       s1_fire;
    logic       emit;
    logic       want_out;
    logic [7:0] tp_start;
    logic [7:0] off8;

    always_comb begin
        n_ether    = r_ether;
        n_hwords   = r_hwords;
        n_proto    = r_proto;
        n_src_addr = r_src_addr;
        n_dst_addr = r_dst_addr;
        n_sport    = r_sport;
        n_dport    = r_dport;

        if (r_offset == ETYPE_HI_OFF) begin
            n_ether[15:8] = r_s1_byte;
        end
        if (r_offset == ETYPE_LO_OFF) begin
            n_ether[7:0] = r_s1_byte;
        end
        if (r_offset == IP_START) begin
            n_hwords = r_s1_byte[3:0];
        end
        if (r_offset == PROTO_OFF) begin
            n_proto = r_s1_byte;
        end
        for (int k = 0; k < 4; k++) begin
            if (r_offset == SRC_ADDR_OFF + t_offset'(k)) begin
                n_src_addr[(3-k)*8 +: 8] = r_s1_byte;
            end
            if (r_offset == DST_ADDR_OFF + t_offset'(k)) begin
                n_dst_addr[(3-k)*8 +: 8] = r_s1_byte;
            end
        end

        // transport header start uses the ihl as updated by this byte
        off8     = {1'b0, r_offset};
        tp_start = {1'b0, IP_START} + {2'b00, n_hwords, 2'b00};
        if (off8 == tp_start) begin
            n_sport[15:8] = r_s1_byte;
        end
        if (off8 == tp_start + 8'd1) begin
            n_sport[7:0] = r_s1_byte;
        end
        if (off8 == tp_start + 8'd2) begin
            n_dport[15:8] = r_s1_byte;
        end
        if (off8 == tp_start + 8'd3) begin
            n_dport[7:0] = r_s1_byte;
        end

        n_offset = (r_offset < OFFSET_MAX) ? r_offset + t_offset'(1) : r_offset;
    end

    always_comb begin
        n_summary              = '0;
        n_summary.frame_length = r_s1_wlen;
        emit                   = 1'b1;
        if (n_ether == ETHERTYPE_IPV4) begin
            if (n_proto inside {PROTO_ICMP, PROTO_TCP, PROTO_UDP}) begin
                n_summary.is_ipv4   = 1'b1;
                n_summary.src_addr  = n_src_addr;
                n_summary.dst_addr  = n_dst_addr;
                n_summary.proto_num = n_proto;
                if (n_proto != PROTO_ICMP) begin
                    n_summary.sport = n_sport;
                    n_summary.dport = n_dport;
                end
            end else begin
                emit = 1'b0;
            end
        end
    end

    assign out_free   = !r_out_valid || o_out.ready;
    assign want_out   = r_s1_last && emit;
    assign s1_fire    = r_s1_valid && (!want_out || out_free);
    assign i_in.ready = !r_s1_valid || s1_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_s1_valid <= i_in.valid;
        end
        if (i_in.ready && i_in.valid) begin
            r_s1_byte <= i_in.data_byte;
            r_s1_last <= i_in.last_byte;
            r_s1_wlen <= i_in.wire_length;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (s1_fire && r_s1_last)) begin
            r_offset   <= '0;
            r_ether    <= '0;
            r_hwords   <= '0;
            r_proto    <= '0;
            r_src_addr <= '0;
            r_dst_addr <= '0;
            r_sport    <= '0;
            r_dport    <= '0;
        end else if (s1_fire) begin
            r_offset   <= n_offset;
            r_ether    <= n_ether;
            r_hwords   <= n_hwords;
            r_proto    <= n_proto;
            r_src_addr <= n_src_addr;
            r_dst_addr <= n_dst_addr;
            r_sport    <= n_sport;
            r_dport    <= n_dport;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_fire && want_out) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
        if (s1_fire && want_out) begin
            r_out <= n_summary;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.frame_length = r_out.frame_length;
    assign o_out.is_ipv4      = r_out.is_ipv4;
    assign o_out.src_addr     = r_out.src_addr;
    assign o_out.dst_addr     = r_out.dst_addr;
    assign o_out.sport        = r_out.sport;
    assign o_out.dport        = r_out.dport;
    assign o_out.proto_num    = r_out.proto_num;

endmodule
